// ===== hdl/lphm_pkg.sv =====
// Package with types and constants, including the hash multiplier, of the hash map unit.
package lphm_pkg;

    localparam int unsigned CAPACITY_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [63:0] HASH_MULT = 64'd11400714819323198485;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_SET = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SPARE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_HIT = 3'd0,
        ST_MISS = 3'd1,
        ST_INSERTED = 3'd2,
        ST_UPDATED = 3'd3,
        ST_FULL = 3'd4,
        ST_DELETED = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_SET = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RD,
        S_WAIT,
        S_CHK,
        S_DEL_RD,
        S_DEL_WAIT,
        S_DEL_CHK,
        S_RI_MUL,
        S_RI_RD,
        S_RI_WAIT,
        S_RI_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op op;
        logic [63:0] key;
        logic [63:0] value;
    } t_req;

endpackage

// ===== hdl/linear_probe_hash_map_unit.sv =====
// A request probes slots in turn from its hashed slot; a delete also rehashes and moves each entry that follows.
// The back part serves one request at a time; the next starts only once the last is done.
// The front queue holds two requests, and a result register lets the next request proceed.
// Reset is synchronous, active low, and clears the entry count at once.
// After reset a clearing pass empties the used marks before requests run.
// Keys and values are undefined until written.
module linear_probe_hash_map_unit
    import lphm_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_lookup_key,
    input  logic [63:0] i_write_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_read_value,
    output logic [10:0] o_entries_held
);

    logic w_req_valid, w_req_ready;
    t_req w_req;

    lphm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_lookup_key(i_lookup_key), .i_write_value(i_write_value),
        .o_req_valid(w_req_valid), .i_req_ready(w_req_ready), .o_req(w_req)
    );

    lphm_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(w_req_valid), .o_req_ready(w_req_ready), .i_req(w_req),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_read_value(o_read_value),
        .o_entries_held(o_entries_held)
    );

endmodule

// ===== hdl/lphm_front.sv =====
// Front part: accepts requests, classifies the mode and queues them.
module lphm_front
    import lphm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_lookup_key,
    input  logic [63:0] i_write_value,
    output logic        o_req_valid,
    input  logic        i_req_ready,
    output t_req        o_req
);

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    t_req          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    t_req          w_req;
    logic          w_push, w_pop;

    always_comb begin
        w_req.key = i_lookup_key;
        w_req.value = i_write_value;
        case (t_mode'(i_mode))
            MODE_SET: w_req.op = OP_SET;
            MODE_DELETE: w_req.op = OP_DELETE;
            default: w_req.op = OP_LOOKUP;
        endcase
    end

    assign o_ready = (r_cnt != (PW+1)'(QUEUE_DEPTH));
    assign w_push = i_valid && o_ready;
    assign o_req_valid = (r_cnt != '0);
    assign w_pop = o_req_valid && i_req_ready;
    assign o_req = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !o_req_valid)
        else $error("empty queue presents a request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("push lost");

endmodule

// ===== hdl/lphm_back.sv =====
// Back part: probes the slot memory and carries out lookups, sets and deletes.
module lphm_back
    import lphm_pkg::*;
#(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_read_value,
    output logic [10:0] o_entries_held
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = AW + 1;
    localparam logic [CW+1:0] FULL_MARK = (CW+2)'(CAPACITY * 3);

    logic [63:0]   r_keys [CAPACITY];
    logic [63:0]   r_vals [CAPACITY];
    logic          r_used [CAPACITY];
    logic [63:0]   r_rd_key, r_rd_val;
    logic          r_rd_used;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    t_state        r_state, n_state;
    t_req          r_req;
    logic [AW-1:0] r_prod;
    logic [AW-1:0] r_pos, r_next;
    logic [CW-1:0] r_steps;
    logic [CW-1:0] r_fill;
    logic [63:0]   r_mkey, r_mval;
    logic          r_out_valid;
    logic [2:0]    r_status;
    logic [63:0]   r_out_val;
    logic [2:0]    r_res_status;
    logic [63:0]   r_res_val;
    logic [10:0]   r_res_held;

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic          w_wr_en, w_wr_used, w_wr_kv;
    logic [AW-1:0] w_wr_addr;
    logic [63:0]   w_wr_key, w_wr_val;
    logic          w_full, w_hit, w_bound;

    assign w_full = ({2'b00, r_fill} << 2) >= FULL_MARK;
    assign w_hit = r_rd_used && (r_rd_key == r_req.key);
    assign w_bound = (r_steps == CW'(CAPACITY - 1));

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_key <= r_keys[w_rd_addr];
            r_rd_val <= r_vals[w_rd_addr];
        end
        if (w_wr_en && w_wr_kv) begin
            r_keys[w_wr_addr] <= w_wr_key;
            r_vals[w_wr_addr] <= w_wr_val;
        end
    end

    // After reset the used marks are cleared one slot per cycle before any request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(CAPACITY - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_used[r_clr_addr] <= 1'b0;
        end else if (w_wr_en) begin
            r_used[w_wr_addr] <= w_wr_used;
        end
        if (w_rd_en) begin
            r_rd_used <= r_used[w_rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req_valid && !r_clr_busy) n_state = S_MUL;
            S_MUL: n_state = S_RD;
            S_RD: n_state = S_WAIT;
            S_WAIT: n_state = S_CHK;
            S_CHK: begin
                if (w_hit || !r_rd_used || w_bound) begin
                    if (r_req.op == OP_DELETE && w_hit) begin
                        n_state = S_DEL_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_DEL_RD: n_state = S_DEL_WAIT;
            S_DEL_WAIT: n_state = S_DEL_CHK;
            S_DEL_CHK: begin
                if (!r_rd_used || w_bound) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RI_MUL;
                end
            end
            S_RI_MUL: n_state = S_RI_RD;
            S_RI_RD: n_state = S_RI_WAIT;
            S_RI_WAIT: n_state = S_RI_CHK;
            S_RI_CHK: begin
                if (!r_rd_used) begin
                    n_state = S_DEL_RD;
                end else begin
                    n_state = S_RI_RD;
                end
            end
            S_DONE: if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_rd_en = 1'b0;
        w_rd_addr = r_pos;
        w_wr_en = 1'b0;
        w_wr_kv = 1'b0;
        w_wr_used = 1'b0;
        w_wr_addr = r_pos;
        w_wr_key = r_req.key;
        w_wr_val = r_req.value;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: o_req_ready = !r_clr_busy;
            S_RD, S_RI_RD: w_rd_en = 1'b1;
            S_DEL_RD: begin
                w_rd_en = 1'b1;
                w_rd_addr = r_next;
            end
            S_CHK: begin
                if (r_req.op == OP_SET && w_hit) begin
                    w_wr_en = 1'b1;
                    w_wr_kv = 1'b1;
                    w_wr_used = 1'b1;
                end else if (r_req.op == OP_SET && !r_rd_used && !w_full) begin
                    w_wr_en = 1'b1;
                    w_wr_kv = 1'b1;
                    w_wr_used = 1'b1;
                end else if (r_req.op == OP_DELETE && w_hit) begin
                    w_wr_en = 1'b1;
                end
            end
            S_DEL_CHK: begin
                if (r_rd_used && !w_bound) begin
                    w_wr_en = 1'b1;
                    w_wr_addr = r_next;
                end
            end
            S_RI_CHK: begin
                if (!r_rd_used) begin
                    w_wr_en = 1'b1;
                    w_wr_kv = 1'b1;
                    w_wr_used = 1'b1;
                    w_wr_key = r_mkey;
                    w_wr_val = r_mval;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        r_req <= i_req;
                        r_prod <= AW'(i_req.key[AW-1:0] * HASH_MULT[AW-1:0]);
                        r_status <= ST_MISS;
                        r_out_val <= '0;
                    end
                end
                S_MUL: begin
                    r_pos <= r_prod;
                    r_steps <= '0;
                end
                S_CHK: begin
                    if (!(w_hit || !r_rd_used || w_bound)) begin
                        r_pos <= r_pos + 1'b1;
                        r_steps <= r_steps + 1'b1;
                    end
                    case (r_req.op)
                        OP_SET: begin
                            if (w_hit) begin
                                r_status <= ST_UPDATED;
                            end else if (!r_rd_used) begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_INSERTED;
                                    r_fill <= r_fill + 1'b1;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (w_hit) begin
                                r_status <= ST_DELETED;
                                r_fill <= r_fill - 1'b1;
                                r_next <= r_pos + 1'b1;
                                r_steps <= '0;
                            end
                        end
                        default: begin
                            if (w_hit) begin
                                r_status <= ST_HIT;
                                r_out_val <= r_rd_val;
                            end
                        end
                    endcase
                end
                S_DEL_CHK: begin
                    if (r_rd_used && !w_bound) begin
                        r_mkey <= r_rd_key;
                        r_mval <= r_rd_val;
                        r_prod <= AW'(r_rd_key[AW-1:0] * HASH_MULT[AW-1:0]);
                    end
                end
                S_RI_MUL: r_pos <= r_prod;
                S_RI_CHK: begin
                    if (!r_rd_used) begin
                        r_next <= r_next + 1'b1;
                        r_steps <= r_steps + 1'b1;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_res_status <= r_status;
                        r_res_val <= r_out_val;
                        r_res_held <= 11'(r_fill);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_status = r_res_status;
    assign o_read_value = r_res_val;
    assign o_entries_held = r_res_held;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count above capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_status))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> (r_state == S_IDLE))
        else $error("request taken while busy");

endmodule
